// File: rtl/ssh_pkg.sv
// Shared types, constants and a helper function for the selectable string hash block.
package ssh_pkg;

  typedef enum logic [2:0] {
    ALG_SDBM = 3'd0,
    ALG_RS   = 3'd1,
    ALG_JS   = 3'd2,
    ALG_PJW  = 3'd3,
    ALG_ELF  = 3'd4,
    ALG_BKDR = 3'd5,
    ALG_DJB  = 3'd6,
    ALG_AP   = 3'd7
  } alg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_string;
  } item_t;

  localparam logic        REG_ALGORITHM = 1'b0;
  localparam logic [31:0] RS_STEP       = 32'd378551;
  localparam logic [31:0] RS_START      = 32'd63689;
  localparam logic [31:0] JS_START      = 32'd1315423911;
  localparam logic [31:0] DJB_START     = 32'd5381;
  localparam logic [31:0] TOP_NIBBLE    = 32'hF000_0000;
  localparam int          RESULT_DEPTH  = 2;

  function automatic logic [31:0] start_value(alg_t alg);
    logic [31:0] v;
    case (alg)
      ALG_JS:  v = JS_START;
      ALG_DJB: v = DJB_START;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/ssh_front.sv
// Input queue that accepts items and drops those that carry neither a byte nor an end mark.
module ssh_front import ssh_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] data_byte,
  input  logic       byte_present,
  input  logic       end_of_string,
  output logic       full,
  output item_t      head,
  output logic       head_valid,
  input  logic       head_pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  item_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          keep;
  logic          take;

  assign full       = (count == FULL_COUNT);
  assign keep       = push && !full && (byte_present || end_of_string);
  assign take       = head_pop && head_valid;
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (keep) begin
      mem[wr_ptr] <= '{data_byte: data_byte, byte_present: byte_present,
                       end_of_string: end_of_string};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (keep) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (keep && !take) begin
        count <= count + 1'b1;
      end else if (take && !keep) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/ssh_back.sv
// Hash core that absorbs queued bytes and holds finished hashes in a two-entry result queue.
module ssh_back import ssh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  alg_t        algorithm,
  input  logic        restart,
  input  item_t       head,
  input  logic        head_valid,
  output logic        head_pop,
  input  logic        pop,
  output logic        empty,
  output logic [30:0] hash_value
);

  logic [31:0] accumulator;
  logic [31:0] accumulator_next;
  logic [31:0] rs_multiplier;
  logic [31:0] rs_multiplier_next;
  logic        position_odd;
  logic        position_odd_next;
  logic [31:0] absorbed;
  logic [31:0] c32;
  logic [31:0] rs_prod;
  logic [31:0] rs_step_prod;
  logic [31:0] shifted;
  logic [31:0] top;
  logic [31:0] ap_mix;
  logic        take;
  logic        emit;
  logic [30:0] result;

  logic [30:0] rq_mem [RESULT_DEPTH];
  logic        rq_wr;
  logic        rq_rd;
  logic [1:0]  rq_count;
  logic        rq_pop;

  assign c32          = {24'd0, head.data_byte};
  assign rs_prod      = accumulator * rs_multiplier;
  assign rs_step_prod = rs_multiplier * RS_STEP;
  assign shifted      = (accumulator << 4) + c32;
  assign top          = shifted & TOP_NIBBLE;

  always_comb begin
    if (position_odd) begin
      ap_mix = accumulator ^ ~((accumulator << 11) ^ c32 ^ (accumulator >> 5));
    end else begin
      ap_mix = accumulator ^ ((accumulator << 7) ^ c32 ^ (accumulator >> 3));
    end
  end

  always_comb begin
    case (algorithm)
      ALG_SDBM: absorbed = c32 + (accumulator << 6) + (accumulator << 16) - accumulator;
      ALG_RS:   absorbed = rs_prod + c32;
      ALG_JS:   absorbed = accumulator ^ ((accumulator << 5) + c32 + (accumulator >> 2));
      ALG_PJW,
      ALG_ELF:  absorbed = (shifted ^ (top >> 24)) & ~top;
      ALG_BKDR: absorbed = (accumulator << 7) + (accumulator << 1) + accumulator + c32;
      ALG_DJB:  absorbed = accumulator + (accumulator << 5) + c32;
      default:  absorbed = ap_mix;
    endcase
  end

  assign rq_pop   = pop && !empty;
  assign head_pop = head_valid &&
                    (!head.end_of_string || (rq_count != 2'(RESULT_DEPTH)) || rq_pop);
  assign take     = head_pop;
  assign emit     = take && head.end_of_string;
  assign result   = head.byte_present ? absorbed[30:0] : accumulator[30:0];

  always_comb begin
    accumulator_next   = accumulator;
    rs_multiplier_next = rs_multiplier;
    position_odd_next  = position_odd;
    if (restart) begin
      accumulator_next   = start_value(algorithm);
      rs_multiplier_next = RS_START;
      position_odd_next  = 1'b0;
    end else if (take) begin
      if (head.byte_present) begin
        accumulator_next   = absorbed;
        rs_multiplier_next = rs_step_prod;
        position_odd_next  = ~position_odd;
      end
      if (head.end_of_string) begin
        accumulator_next   = start_value(algorithm);
        rs_multiplier_next = RS_START;
        position_odd_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= start_value(ALG_SDBM);
      rs_multiplier <= RS_START;
      position_odd  <= 1'b0;
    end else begin
      accumulator   <= accumulator_next;
      rs_multiplier <= rs_multiplier_next;
      position_odd  <= position_odd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rq_mem[rq_wr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr    <= 1'b0;
      rq_rd    <= 1'b0;
      rq_count <= 2'd0;
    end else begin
      if (emit) begin
        rq_wr <= ~rq_wr;
      end
      if (rq_pop) begin
        rq_rd <= ~rq_rd;
      end
      if (emit && !rq_pop) begin
        rq_count <= rq_count + 2'd1;
      end else if (rq_pop && !emit) begin
        rq_count <= rq_count - 2'd1;
      end
    end
  end

  assign empty      = (rq_count == 2'd0);
  assign hash_value = rq_mem[rq_rd];

`ifndef SYNTHESIS
  a_rq_bound: assert property (@(posedge clk) disable iff (rst)
    rq_count <= 2'(RESULT_DEPTH))
    else $error("result queue count exceeds its depth");

  a_restart_state: assert property (@(posedge clk) disable iff (rst)
    restart |=> (rs_multiplier == RS_START) && !position_odd)
    else $error("restart did not reinitialize the hash state");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    emit && !rq_pop |=> rq_count == $past(rq_count) + 2'd1)
    else $error("finished hash was not queued");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    emit |-> (rq_count != 2'(RESULT_DEPTH)) || rq_pop)
    else $error("hash emitted into a full result queue");
`endif

endmodule

// File: rtl/selectable_string_hash_top.sv
// Top level of the selectable string hash block with its register port.
//
//  Channel  Direction  Handshake            Beat
//  input    in         push / full          data_byte, byte_present, end_of_string
//  result   out        pop / empty          hash_value
//  config   in         psel/penable/pready  algorithm at byte address 0
//
// One item is taken per cycle unless an end item stalls; the accumulator update,
// including the 32x32 multiply for RS, is combinational within the hash core.
// A result can be popped once its end item has left the input queue and its hash is queued.
// Synchronous rst empties both queues and selects SDBM with its initial state.
// full rises when four items wait; an end item stalls while two results sit unpopped.
module selectable_string_hash_top import ssh_pkg::*; #(
  parameter int ITEM_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_string,
  output logic        empty,
  input  logic        pop,
  output logic [30:0] hash_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  alg_t  algorithm;
  logic  cfg_write;
  logic  restart;
  item_t head;
  logic  head_valid;
  logic  head_pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign restart   = cfg_write && (paddr[2] == REG_ALGORITHM);
  assign prdata    = (paddr[2] == REG_ALGORITHM) ? {29'd0, algorithm} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      algorithm <= ALG_SDBM;
    end else if (restart) begin
      algorithm <= alg_t'(pwdata[2:0]);
    end
  end

  ssh_front #(
    .DEPTH (ITEM_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .data_byte     (data_byte),
    .byte_present  (byte_present),
    .end_of_string (end_of_string),
    .full          (full),
    .head          (head),
    .head_valid    (head_valid),
    .head_pop      (head_pop)
  );

  ssh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .algorithm  (alg_t'(restart ? pwdata[2:0] : algorithm)),
    .restart    (restart),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .pop        (pop),
    .empty      (empty),
    .hash_value (hash_value)
  );

endmodule

// File: tb/selectable_string_hash_top_test.sv
// Self-checking testbench for the selectable string hash block: directed and random strings.
`timescale 1ns / 100ps

module selectable_string_hash_top_test;
  import ssh_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_BEATS = 330;
  localparam logic [2:0] ALG_ADDR = {REG_ALGORITHM, 2'b00};
  localparam logic [2:0] SPARE_ADDR = {~REG_ALGORITHM, 2'b00};
  localparam logic [31:0] BKDR_MULT = 32'd131;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [7:0] data_byte = 8'd0;
  logic byte_present = 1'b0;
  logic end_of_string = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [30:0] hash_value;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic pready;

  alg_t cur_alg = ALG_SDBM;
  logic [31:0] hash_acc = 32'd0;
  logic [31:0] rs_mult = RS_START;
  logic pos_odd = 1'b0;
  logic [30:0] expected_hash[$];
  int mismatch_count = 0;
  int beats_sent = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_request = 1'b0;
  int hold_count = 0;
  int idle_cycles = 0;

  selectable_string_hash_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .data_byte(data_byte),
    .byte_present(byte_present), .end_of_string(end_of_string), .empty(empty),
    .pop(pop), .hash_value(hash_value), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] seed_of(alg_t a);
    logic [31:0] s;
    case (a)
      ALG_JS:  s = JS_START;
      ALG_DJB: s = DJB_START;
      default: s = 32'd0;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] next_hash(alg_t a, logic [31:0] h, logic [7:0] b,
                                            logic [31:0] m, logic odd);
    logic [31:0] c;
    logic [31:0] t;
    logic [31:0] top;
    logic [31:0] r;
    c = {24'd0, b};
    case (a)
      ALG_SDBM: r = c + (h << 6) + (h << 16) - h;
      ALG_RS:   r = h * m + c;
      ALG_JS:   r = h ^ ((h << 5) + c + (h >> 2));
      ALG_PJW, ALG_ELF: begin
        t = (h << 4) + c;
        top = t & TOP_NIBBLE;
        if (top != 32'd0) begin
          t = t ^ (top >> 24);
          t = t & ~top;
        end
        r = t;
      end
      ALG_BKDR: r = h * BKDR_MULT + c;
      ALG_DJB:  r = h + (h << 5) + c;
      default: begin
        if (!odd) r = h ^ ((h << 7) ^ c ^ (h >> 3));
        else r = h ^ ~((h << 11) ^ c ^ (h >> 5));
      end
    endcase
    return r;
  endfunction

  task automatic restart_hash();
    hash_acc = seed_of(cur_alg);
    rs_mult = RS_START;
    pos_odd = 1'b0;
  endtask

  task automatic send_item(input logic [7:0] b, input logic p, input logic e);
    push <= 1'b1;
    data_byte <= b;
    byte_present <= p;
    end_of_string <= e;
    do @(posedge clk); while (full);
    if (p) begin
      hash_acc = next_hash(cur_alg, hash_acc, b, rs_mult, pos_odd);
      rs_mult = rs_mult * RS_STEP;
      pos_odd = ~pos_odd;
    end
    if (e) begin
      expected_hash.push_back(hash_acc[30:0]);
      restart_hash();
    end
    if (p || e) beats_sent++;
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (expected_hash.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_register(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] rd;
    wait_idle();
    apb_access(1'b1, addr, value, rd);
    if (addr[2] == REG_ALGORITHM) begin
      cur_alg = alg_t'(value[2:0]);
      restart_hash();
    end
    apb_access(1'b0, ALG_ADDR, 32'd0, rd);
    if (rd !== 32'(cur_alg)) begin
      $display("%0t: algorithm readback expected %0d actual %0d", $time, cur_alg, rd);
      mismatch_count++;
    end
  endtask

  task automatic send_random_string(input bit closed);
    int len;
    len = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(10);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, 1'b0);
    end
    if (closed) send_item(8'($urandom), 1'($urandom), 1'b1);
  endtask

  task automatic test_reset_state();
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b1);
  endtask

  task automatic test_each_algorithm();
    for (int a = 0; a < 8; a++) begin
      set_register(ALG_ADDR, 32'(a));
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'h80, 1'b1, 1'b1);
    end
  endtask

  task automatic test_special_cases();
    set_register(ALG_ADDR, 32'(ALG_RS));
    send_item(8'h41, 1'b1, 1'b0);
    send_item(8'h7F, 1'b0, 1'b0);
    send_item(8'h42, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b1);
    send_item(8'h31, 1'b1, 1'b0);
    send_item(8'h32, 1'b1, 1'b0);
    set_register(ALG_ADDR, 32'(ALG_AP));
    send_item(8'h00, 1'b0, 1'b1);
    set_register(SPARE_ADDR, $urandom);
    send_item(8'hA5, 1'b1, 1'b1);
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_stall = 0;
    hold_request = 1'b1;
    for (int i = 0; i < 20; i++) send_random_string(1'b1);
    wait_idle();
    for (int i = 0; i < 10; i++) send_random_string(1'b1);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int target;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 63; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 63; end
        default: begin send_idle = 29; recv_stall = 29; end
      endcase
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) begin
        if ($urandom_range(19) == 0) begin
          if ($urandom_range(2) == 0) send_random_string(1'b0);
          set_register(ALG_ADDR, $urandom_range(7));
        end
        send_random_string(1'b1);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_count = HOLD_CYCLES;
      end
      if (hold_count > 0) begin
        hold_count--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  always @(posedge clk) begin
    logic [30:0] want;
    if (!rst && pop && !empty) begin
      if (expected_hash.size() == 0) begin
        $display("%0t: unexpected hash expected none actual %h", $time, hash_value);
        mismatch_count++;
      end else begin
        want = expected_hash.pop_front();
        if (hash_value !== want) begin
          $display("%0t: hash_value expected %h actual %h", $time, want, hash_value);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("selectable_string_hash_top_test NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_each_algorithm();
    test_special_cases();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("selectable_string_hash_top_test OK");
    end else begin
      $display("selectable_string_hash_top_test NOT OK");
    end
    $finish;
  end

endmodule
